// ===== rtl/core/bba_pkg.sv =====
package bba_pkg;

	localparam int ACT_W = 2;
	localparam int BLK_W = 13;
	localparam int CNT_W = 14;

	localparam int ALLOC_LIMIT = 8064;
	localparam int DIV_SH = 20;

	typedef logic [ACT_W-1:0] action_t;
	typedef logic [BLK_W-1:0] block_t;
	typedef logic [CNT_W-1:0] count_t;

	localparam action_t ACT_ALLOC = 2'd0;
	localparam action_t ACT_FREE  = 2'd1;
	localparam action_t ACT_MARK  = 2'd2;

endpackage

// ===== rtl/core/bba_req_if.sv =====
interface bba_req_if;
	import bba_pkg::*;

	logic valid;
	logic ready;
	action_t action;
	block_t block_index;

	modport source (output valid, output action, output block_index, input ready);
	modport sink (input valid, input action, input block_index, output ready);
	modport monitor (input valid, input action, input block_index, input ready);

endinterface

// ===== rtl/core/bba_rsp_if.sv =====
interface bba_rsp_if;
	import bba_pkg::*;

	logic valid;
	logic ready;
	block_t granted_block;
	logic ok;
	count_t free_count;

	modport source (output valid, output granted_block, output ok, output free_count,
		input ready);
	modport sink (input valid, input granted_block, input ok, input free_count,
		output ready);
	modport monitor (input valid, input granted_block, input ok, input free_count,
		input ready);

endinterface

// ===== rtl/core/bba_map_ram.sv =====
module bba_map_ram #(
	parameter int WORDS = 256,
	parameter int WIDTH = 32,
	parameter int AW = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/bba_find.sv =====
module bba_find #(
	parameter int WIDTH = 32,
	parameter int OFF_W = 5,
	parameter int LAST_B = 31
) (
	input  logic [WIDTH-1:0] word,
	input  logic             is_start,
	input  logic [OFF_W-1:0] start_off,
	input  logic             is_last,
	output logic             found,
	output logic [OFF_W-1:0] bit_pos
);

	logic [WIDTH-1:0] cand;

	always_comb begin
		for (int b = 0; b < WIDTH; b++) begin
			cand[b] = !word[b]
				&& (!is_start || (OFF_W'(b) >= start_off))
				&& (!is_last || (b <= LAST_B));
		end
	end

	always_comb begin
		bit_pos = '0;
		for (int b = WIDTH - 1; b >= 0; b--) begin
			if (cand[b]) begin
				bit_pos = OFF_W'(b);
			end
		end
	end

	assign found = |cand;

endmodule

// ===== rtl/core/bitmap_block_allocator.sv =====
// Bitmap first-fit block allocator.
// Channel req (sink): action and block_index. Channel rsp (source): granted_block,
// ok and free_count. Both move one item per transfer (valid and ready high at a
// rising edge of clk).
// Allocate scans the occupancy map upward from block_index, one map word per
// cycle, and claims the first clear bit inside the allocation window. Free and
// mark-used touch one word with a single read-modify-write.
// A request passes the divide and issue states, then scan (allocate) or modify
// (free, mark-used), then finish; a rejected request skips from issue to finish.
// A scan reads at most ceil(min(8064, NUM_BLOCKS) / WORD_BITS) words, 252 by default.
// One request is in work at a time; the map memory port sets the scan rate.
// The result sits in an output register, so a new request is taken while
// a result waits; a stalled rsp holds the block in its finish state only
// once a second result is ready.
// After arst_n the map is swept to zero, one word per cycle, over all
// ceil(NUM_BLOCKS / WORD_BITS) map words (256 by default); req.ready stays low
// during the sweep. The internal free count resets to NUM_BLOCKS.
module bitmap_block_allocator #(
	parameter int NUM_BLOCKS = 8192,
	parameter int WORD_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	bba_req_if.sink req,
	bba_rsp_if.source rsp
);
	import bba_pkg::*;

	localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int OFF_W = $clog2(WORD_BITS);
	localparam int LIMIT = (ALLOC_LIMIT < NUM_BLOCKS) ? ALLOC_LIMIT : NUM_BLOCKS;
	localparam int LAST_W = (LIMIT - 1) / WORD_BITS;
	localparam int LAST_B = (LIMIT - 1) % WORD_BITS;
	localparam int RECIP = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W = BLK_W + DIV_SH;
	localparam int RANGE_W = 17;
	localparam logic [RANGE_W-1:0] LIMIT_V = RANGE_W'(LIMIT);
	localparam logic [RANGE_W-1:0] NB_V = RANGE_W'(NUM_BLOCKS);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_ISSUE = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_MOD   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] st_q;
	logic [AW-1:0] clr_q;
	action_t act_q;
	block_t idx_q;
	block_t q_q;
	logic [OFF_W-1:0] off_q;
	logic [AW-1:0] cur_s1;
	logic [AW-1:0] gw_q;
	logic [OFF_W-1:0] gb_q;
	logic ok_q;
	count_t cnt_q;

	logic rsp_vld_q;
	block_t rsp_blk_q;
	logic rsp_ok_q;
	count_t rsp_cnt_q;

	logic we;
	logic [AW-1:0] waddr;
	logic [WORD_BITS-1:0] wdata;
	logic re;
	logic [AW-1:0] raddr;
	logic [WORD_BITS-1:0] rdata;

	logic [PROD_W-1:0] prod;
	block_t rem;
	logic in_range;
	logic is_start;
	logic is_last;
	logic found;
	logic [OFF_W-1:0] fb;
	logic [WORD_BITS-1:0] fb_mask;
	logic [WORD_BITS-1:0] off_mask;
	logic cur_bit;
	logic mod_change;
	logic out_load;
	block_t gnt;

	assign req.ready = (st_q == ST_IDLE);

	assign prod = PROD_W'(idx_q) * PROD_W'(RECIP);
	assign rem = idx_q - BLK_W'(q_q * BLK_W'(WORD_BITS));

	always_comb begin
		case (act_q)
			ACT_ALLOC: in_range = {{(RANGE_W-BLK_W){1'b0}}, idx_q} < LIMIT_V;
			ACT_FREE, ACT_MARK: in_range = {{(RANGE_W-BLK_W){1'b0}}, idx_q} < NB_V;
			default: in_range = 1'b0;
		endcase
	end

	assign is_start = (cur_s1 == q_q[AW-1:0]);
	assign is_last = (cur_s1 == AW'(LAST_W));

	bba_find #(
		.WIDTH(WORD_BITS),
		.OFF_W(OFF_W),
		.LAST_B(LAST_B)
	) u_find (
		.word(rdata),
		.is_start(is_start),
		.start_off(off_q),
		.is_last(is_last),
		.found(found),
		.bit_pos(fb)
	);

	assign fb_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << fb;
	assign off_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << off_q;
	assign cur_bit = rdata[off_q];
	assign mod_change = (act_q == ACT_FREE) ? cur_bit : !cur_bit;

	always_comb begin
		we = 1'b0;
		waddr = cur_s1;
		wdata = rdata;
		re = 1'b0;
		raddr = cur_s1;
		case (st_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_ISSUE: begin
				re = in_range;
				raddr = q_q[AW-1:0];
			end
			ST_SCAN: begin
				if (found) begin
					we = 1'b1;
					wdata = rdata | fb_mask;
				end else if (!is_last) begin
					re = 1'b1;
					raddr = cur_s1 + AW'(1);
				end
			end
			ST_MOD: begin
				we = mod_change;
				wdata = rdata ^ off_mask;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	bba_map_ram #(
		.WORDS(MAP_WORDS),
		.WIDTH(WORD_BITS),
		.AW(AW)
	) u_map (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign out_load = (st_q == ST_FIN) && (!rsp_vld_q || rsp.ready);
	assign gnt = (ok_q && (act_q == ACT_ALLOC))
		? BLK_W'(BLK_W'(gw_q) * BLK_W'(WORD_BITS)) + BLK_W'(gb_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			cnt_q <= CNT_W'(NUM_BLOCKS);
			ok_q <= 1'b0;
		end else begin
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_WORDS - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					st_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					ok_q <= 1'b0;
					if (!in_range) begin
						st_q <= ST_FIN;
					end else if (act_q == ACT_ALLOC) begin
						st_q <= ST_SCAN;
					end else begin
						st_q <= ST_MOD;
					end
				end
				ST_SCAN: begin
					if (found) begin
						ok_q <= 1'b1;
						cnt_q <= cnt_q - CNT_W'(1);
						st_q <= ST_FIN;
					end else if (is_last) begin
						st_q <= ST_FIN;
					end
				end
				ST_MOD: begin
					ok_q <= mod_change;
					if (mod_change) begin
						cnt_q <= (act_q == ACT_FREE) ? cnt_q + CNT_W'(1) : cnt_q - CNT_W'(1);
					end
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q <= req.action;
			idx_q <= req.block_index;
		end
		if (st_q == ST_DIV) begin
			q_q <= prod[DIV_SH +: BLK_W];
		end
		if (st_q == ST_ISSUE) begin
			off_q <= rem[OFF_W-1:0];
			cur_s1 <= q_q[AW-1:0];
		end
		if (st_q == ST_SCAN) begin
			if (found) begin
				gw_q <= cur_s1;
				gb_q <= fb;
			end else begin
				cur_s1 <= cur_s1 + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (out_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_blk_q <= gnt;
			rsp_ok_q <= ok_q;
			rsp_cnt_q <= cnt_q;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.granted_block = rsp_blk_q;
	assign rsp.ok = rsp_ok_q;
	assign rsp.free_count = rsp_cnt_q;

endmodule

// ===== rtl/core/bba_checker.sv =====
module bba_checker #(
	parameter int NUM_BLOCKS = 8192
) (
	input logic clk,
	input logic arst_n,
	bba_req_if.sink req,
	bba_rsp_if.source rsp
);
	import bba_pkg::*;

	localparam int LIMIT = (ALLOC_LIMIT < NUM_BLOCKS) ? ALLOC_LIMIT : NUM_BLOCKS;
	localparam bit CNT_FITS = NUM_BLOCKS < (1 << CNT_W);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.granted_block)
			&& $stable(rsp.ok) && $stable(rsp.free_count))
		else $error("response changed while stalled");

	a_grant_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.granted_block != '0) |-> rsp.ok)
		else $error("nonzero block granted without ok");

	a_grant_window: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (32'(rsp.granted_block) < LIMIT))
		else $error("granted block outside allocation window");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !CNT_FITS || (32'(rsp.free_count) <= NUM_BLOCKS))
		else $error("free count above block count");

endmodule

bind bitmap_block_allocator bba_checker #(
	.NUM_BLOCKS(NUM_BLOCKS)
) u_bba_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req(req),
	.rsp(rsp)
);
